// File: sv/irt_pkg.sv
// Shared types and codes for the impairment rule table.
`default_nettype none
package irt_pkg;

  // Request codes
  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_COMPOSE = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXISTS    = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Rule directions
  localparam logic [1:0] DIR_BOTH = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Rule kinds
  localparam logic [3:0] KIND_LATENCY   = 4'd0;
  localparam logic [3:0] KIND_JITTER    = 4'd1;
  localparam logic [3:0] KIND_SLOWCLOSE = 4'd2;
  localparam logic [3:0] KIND_CHUNK     = 4'd3;
  localparam logic [3:0] KIND_RATE      = 4'd4;
  localparam logic [3:0] KIND_DRIP      = 4'd5;
  localparam logic [3:0] KIND_LOSSY     = 4'd6;
  localparam logic [3:0] KIND_CORRUPT   = 4'd7;
  localparam logic [3:0] KIND_DUP       = 4'd8;
  localparam logic [3:0] KIND_REORDER   = 4'd9;
  localparam logic [3:0] KIND_TRUNCATE  = 4'd10;

  // Lever indexes
  localparam logic [3:0] LEV_LATENCY     = 4'd0;
  localparam logic [3:0] LEV_JITTER      = 4'd1;
  localparam logic [3:0] LEV_SLOWCLOSE   = 4'd2;
  localparam logic [3:0] LEV_CHUNK       = 4'd3;
  localparam logic [3:0] LEV_RATE        = 4'd4;
  localparam logic [3:0] LEV_DRIP_BYTES  = 4'd5;
  localparam logic [3:0] LEV_DRIP_MS     = 4'd6;
  localparam logic [3:0] LEV_LOSSY       = 4'd7;
  localparam logic [3:0] LEV_CORRUPT     = 4'd8;
  localparam logic [3:0] LEV_DUP         = 4'd9;
  localparam logic [3:0] LEV_REORDER     = 4'd10;
  localparam logic [3:0] LEV_REORDER_MS  = 4'd11;
  localparam logic [3:0] LEV_TRUNCATE    = 4'd12;

  localparam logic [31:0] PPM_LIMIT = 32'd1000000;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  kind;
    logic [1:0]  dir;
    logic [31:0] primary;
    logic [31:0] secondary;
  } rule_t;

endpackage
`default_nettype wire

// File: sv/irt_req_if.sv
// Request channel of the impairment rule table.
`default_nettype none
interface irt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] entry_key;
  logic [3:0]  toxic_kind;
  logic [1:0]  entry_dir;
  logic [31:0] value_a;
  logic [31:0] value_b;
  logic        query_down;
  logic [3:0]  lever_index;
  logic [31:0] base_value;

  modport source (
    output valid, req_type, entry_key, toxic_kind, entry_dir, value_a, value_b,
           query_down, lever_index, base_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_key, toxic_kind, entry_dir, value_a, value_b,
           query_down, lever_index, base_value,
    output ready
  );
endinterface
`default_nettype wire

// File: sv/irt_rsp_if.sv
// Result channel of the impairment rule table.
`default_nettype none
interface irt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] lever_value;

  modport source (output valid, status, lever_value, input ready);
  modport sink   (input valid, status, lever_value, output ready);
endinterface
`default_nettype wire

// File: sv/impairment_rule_table.sv
// Add, remove and compose scan the table in order; add and remove stop at a matching key.
// The scan reads one table entry per cycle through the single read port.
// Remove then shifts each later entry down, with a read state then a write state per entry;
// clear skips the scan and goes straight to the done state.
// One request at a time; the next is taken the cycle after the result is registered.
// Reset empties the table at once (rule count to zero); no clearing pass.
`default_nettype none
module impairment_rule_table
  import irt_pkg::*;
#(
  parameter int MAX_RULES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  irt_req_if.sink   req,
  irt_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SHRD = 3'd2;
  localparam logic [2:0] S_SHWR = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] rule_count;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] sh_idx;
  logic [IDX_W-1:0] data_idx;
  logic             pend;
  logic [1:0]       req_type_q;
  logic             down_q;
  logic [3:0]       lever_q;
  logic [31:0]      acc;
  rule_t            new_rule;
  logic [1:0]       res_status;

  logic             out_valid;
  logic [1:0]       out_status;
  logic [31:0]      out_lever;
  logic             out_load;

  rule_t            mem [MAX_RULES];
  rule_t            rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  rule_t            mem_wd;

  logic             accept;
  logic             issue;
  logic             key_hit;
  logic             scan_end;
  logic             table_full;
  logic [CNT_W-1:0] sh_next;
  logic [31:0]      fold_acc;
  logic [31:0]      acc_clamped;
  logic             ppm_lever;

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign issue      = (state == S_SCAN) && (rd_idx < rule_count);
  assign key_hit    = pend && (rd_data.key == new_rule.key) &&
                      (req_type_q == REQ_ADD || req_type_q == REQ_REMOVE);
  assign scan_end   = (state == S_SCAN) && !issue && !pend;
  assign table_full = (rule_count == CNT_W'(MAX_RULES));
  assign sh_next    = sh_idx + CNT_W'(1);
  assign ppm_lever  = (lever_q == LEV_LOSSY) || (lever_q == LEV_CORRUPT) ||
                      (lever_q == LEV_DUP) || (lever_q == LEV_REORDER);
  assign acc_clamped = (ppm_lever && acc > PPM_LIMIT) ? PPM_LIMIT : acc;
  assign out_load   = (state == S_DONE) && (!out_valid || rsp.ready);

  assign rd_addr = (state == S_SHRD) ? sh_next[IDX_W-1:0] : rd_idx[IDX_W-1:0];
  assign mem_we  = (state == S_SHWR) ||
                   (scan_end && req_type_q == REQ_ADD && !table_full);
  assign mem_wa  = (state == S_SHWR) ? sh_idx[IDX_W-1:0] : rule_count[IDX_W-1:0];
  assign mem_wd  = (state == S_SHWR) ? rd_data : new_rule;

  irt_fold u_fold (
    .lever      (lever_q),
    .query_down (down_q),
    .entry      (rd_data),
    .acc        (acc),
    .acc_next   (fold_acc)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rule_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_type_q         <= req.req_type;
            new_rule.key       <= req.entry_key;
            new_rule.kind      <= req.toxic_kind;
            new_rule.dir       <= req.entry_dir;
            new_rule.primary   <= req.value_a;
            new_rule.secondary <= req.value_b;
            down_q             <= req.query_down;
            lever_q            <= req.lever_index;
            acc                <= req.base_value;
            rd_idx             <= '0;
            pend               <= 1'b0;
            res_status         <= ST_OK;
            if (req.req_type == REQ_CLEAR) begin
              rule_count <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (pend && req_type_q == REQ_COMPOSE) begin
            acc <= fold_acc;
          end
          if (key_hit && req_type_q == REQ_ADD) begin
            res_status <= ST_EXISTS;
            pend       <= 1'b0;
            state      <= S_DONE;
          end else if (key_hit) begin
            // close the gap left by the removed entry
            sh_idx <= CNT_W'(data_idx);
            pend   <= 1'b0;
            state  <= S_SHRD;
          end else if (scan_end) begin
            priority case (req_type_q)
              REQ_ADD: begin
                if (table_full) begin
                  res_status <= ST_FULL;
                end else begin
                  rule_count <= rule_count + CNT_W'(1);
                end
              end
              REQ_REMOVE: res_status <= ST_NOT_FOUND;
              default:    acc        <= acc_clamped;
            endcase
            state <= S_DONE;
          end else begin
            pend     <= issue;
            rd_idx   <= rd_idx + CNT_W'(issue);
            data_idx <= rd_idx[IDX_W-1:0];
          end
        end
        S_SHRD: begin
          if (sh_next < rule_count) begin
            state <= S_SHWR;
          end else begin
            rule_count <= rule_count - CNT_W'(1);
            state      <= S_DONE;
          end
        end
        S_SHWR: begin
          sh_idx <= sh_next;
          state  <= S_SHRD;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_status <= res_status;
            out_lever  <= (req_type_q == REQ_COMPOSE) ? acc : 32'd0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.lever_value = out_lever;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rule_count <= CNT_W'(MAX_RULES))
    else $error("rule count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    rule_count != $past(rule_count) |->
      (rule_count == $past(rule_count) + CNT_W'(1)) ||
      (rule_count == $past(rule_count) - CNT_W'(1)) || (rule_count == '0))
    else $error("rule count moved by more than one entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == REQ_CLEAR |=> rule_count == '0)
    else $error("clear request left entries in the table");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> rd_idx <= rule_count)
    else $error("scan ran past the last entry");

endmodule
`default_nettype wire

// File: sv/irt_fold.sv
// Fold unit: merges one rule into the running lever value.
`default_nettype none
module irt_fold
  import irt_pkg::*;
(
  input  wire logic [3:0]  lever,
  input  wire logic        query_down,
  input  rule_t            entry,
  input  wire logic [31:0] acc,
  output logic      [31:0] acc_next
);

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_SUM_A  = 3'd1;
  localparam logic [2:0] OP_SUM_B  = 3'd2;
  localparam logic [2:0] OP_MIN_A  = 3'd3;
  localparam logic [2:0] OP_LAST_B = 3'd4;

  logic [2:0]  op;
  logic [3:0]  want_kind;
  logic        dir_ok;
  logic        apply;
  logic [31:0] operand;
  logic [32:0] sum;

  always_comb begin
    op        = OP_NONE;
    want_kind = KIND_LATENCY;
    unique case (lever)
      LEV_LATENCY:    begin op = OP_SUM_A;  want_kind = KIND_LATENCY;   end
      LEV_JITTER:     begin op = OP_SUM_A;  want_kind = KIND_JITTER;    end
      LEV_SLOWCLOSE:  begin op = OP_SUM_A;  want_kind = KIND_SLOWCLOSE; end
      LEV_CHUNK:      begin op = OP_MIN_A;  want_kind = KIND_CHUNK;     end
      LEV_RATE:       begin op = OP_MIN_A;  want_kind = KIND_RATE;      end
      LEV_DRIP_BYTES: begin op = OP_MIN_A;  want_kind = KIND_DRIP;      end
      LEV_DRIP_MS:    begin op = OP_SUM_B;  want_kind = KIND_DRIP;      end
      LEV_LOSSY:      begin op = OP_SUM_A;  want_kind = KIND_LOSSY;     end
      LEV_CORRUPT:    begin op = OP_SUM_A;  want_kind = KIND_CORRUPT;   end
      LEV_DUP:        begin op = OP_SUM_A;  want_kind = KIND_DUP;       end
      LEV_REORDER:    begin op = OP_SUM_A;  want_kind = KIND_REORDER;   end
      LEV_REORDER_MS: begin op = OP_LAST_B; want_kind = KIND_REORDER;   end
      LEV_TRUNCATE:   begin op = OP_MIN_A;  want_kind = KIND_TRUNCATE;  end
      default:        begin op = OP_NONE;   want_kind = KIND_LATENCY;   end
    endcase
  end

  assign dir_ok = (entry.dir == DIR_BOTH) || (entry.dir == DIR_UP && !query_down) ||
                  (entry.dir == DIR_DOWN && query_down);
  assign apply   = dir_ok && (entry.kind == want_kind);
  assign operand = (op == OP_SUM_B || op == OP_LAST_B) ? entry.secondary : entry.primary;
  assign sum     = {1'b0, acc} + {1'b0, operand};

  always_comb begin
    acc_next = acc;
    if (apply) begin
      unique case (op)
        OP_SUM_A, OP_SUM_B: acc_next = sum[32] ? '1 : sum[31:0];
        OP_MIN_A:  acc_next = (operand != '0 && (acc == '0 || operand < acc)) ? operand : acc;
        OP_LAST_B: acc_next = (operand != '0) ? operand : acc;
        default:   acc_next = acc;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench of the impairment rule table: directed and random requests.
`timescale 1ns / 1ps
module testbench;
  import irt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_REQS = 1700;
  localparam int KEY_POOL    = 20;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 60;
  localparam int PRESSURE_AT = 300;
  localparam int PRESSURE_LEN = 500;

  typedef struct {
    logic [1:0]  req_type;
    logic [63:0] entry_key;
    logic [3:0]  toxic_kind;
    logic [1:0]  entry_dir;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic        query_down;
    logic [3:0]  lever_index;
    logic [31:0] base_value;
  } table_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] lever_value;
  } table_rsp_t;

  logic clk;
  logic rst;

  irt_req_if req_if ();
  irt_rsp_if rsp_if ();

  impairment_rule_table #(.MAX_RULES(TABLE_DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the rule table
  rule_t       shadow_rules [TABLE_DEPTH];
  int          shadow_count;

  table_req_t  queued_requests[$];
  table_rsp_t  awaited_results[$];
  logic [63:0] key_pool [KEY_POOL];

  int total_reqs;
  int accepted_cnt;
  int returned_cnt;
  int error_cnt;
  int req_seen [4];
  int status_seen [4];

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] smaller_nonzero(logic [31:0] cur, logic [31:0] v);
    if (v != 0 && (cur == 0 || v < cur)) return v;
    return cur;
  endfunction

  function automatic logic [31:0] fold_rule(logic [3:0] lever, rule_t r, logic [31:0] acc);
    case (lever)
      LEV_LATENCY:    return (r.kind == KIND_LATENCY)   ? sat_sum(acc, r.primary) : acc;
      LEV_JITTER:     return (r.kind == KIND_JITTER)    ? sat_sum(acc, r.primary) : acc;
      LEV_SLOWCLOSE:  return (r.kind == KIND_SLOWCLOSE) ? sat_sum(acc, r.primary) : acc;
      LEV_CHUNK:      return (r.kind == KIND_CHUNK) ? smaller_nonzero(acc, r.primary) : acc;
      LEV_RATE:       return (r.kind == KIND_RATE)  ? smaller_nonzero(acc, r.primary) : acc;
      LEV_DRIP_BYTES: return (r.kind == KIND_DRIP)  ? smaller_nonzero(acc, r.primary) : acc;
      LEV_DRIP_MS:    return (r.kind == KIND_DRIP)      ? sat_sum(acc, r.secondary) : acc;
      LEV_LOSSY:      return (r.kind == KIND_LOSSY)     ? sat_sum(acc, r.primary) : acc;
      LEV_CORRUPT:    return (r.kind == KIND_CORRUPT)   ? sat_sum(acc, r.primary) : acc;
      LEV_DUP:        return (r.kind == KIND_DUP)       ? sat_sum(acc, r.primary) : acc;
      LEV_REORDER:    return (r.kind == KIND_REORDER)   ? sat_sum(acc, r.primary) : acc;
      LEV_REORDER_MS: return (r.kind == KIND_REORDER && r.secondary != 0) ? r.secondary : acc;
      LEV_TRUNCATE:   return (r.kind == KIND_TRUNCATE)
                             ? smaller_nonzero(acc, r.primary) : acc;
      default:        return acc;
    endcase
  endfunction

  function automatic int find_rule(logic [63:0] key);
    for (int k = 0; k < shadow_count; k++)
      if (shadow_rules[k].key == key) return k;
    return -1;
  endfunction

  // Apply one accepted request to the shadow table and queue the result it should give
  task automatic apply_request(table_req_t r);
    table_rsp_t res;
    int pos;
    logic [31:0] acc;
    logic [1:0] d;
    res.status = ST_OK;
    res.lever_value = '0;
    case (r.req_type)
      REQ_ADD: begin
        if (find_rule(r.entry_key) >= 0) begin
          res.status = ST_EXISTS;
        end else if (shadow_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_rules[shadow_count] = '{key: r.entry_key, kind: r.toxic_kind,
                                         dir: r.entry_dir, primary: r.value_a,
                                         secondary: r.value_b};
          shadow_count++;
        end
      end
      REQ_REMOVE: begin
        pos = find_rule(r.entry_key);
        if (pos < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int k = pos; k + 1 < shadow_count; k++) shadow_rules[k] = shadow_rules[k + 1];
          shadow_count--;
        end
      end
      REQ_CLEAR: shadow_count = 0;
      default: begin
        acc = r.base_value;
        for (int k = 0; k < shadow_count; k++) begin
          d = shadow_rules[k].dir;
          if (d == DIR_BOTH || (d == DIR_UP && !r.query_down) || (d == DIR_DOWN && r.query_down))
            acc = fold_rule(r.lever_index, shadow_rules[k], acc);
        end
        if (r.lever_index >= LEV_LOSSY && r.lever_index <= LEV_REORDER && acc > PPM_LIMIT)
          acc = PPM_LIMIT;
        res.lever_value = acc;
      end
    endcase
    req_seen[r.req_type]++;
    status_seen[res.status]++;
    awaited_results.push_back(res);
  endtask

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return 32'd0;
    if (sel < 40) return 32'($urandom_range(1, 50));
    if (sel < 55) return 32'($urandom_range(999_000, 1_001_000));
    if (sel < 70) return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
    return $urandom;
  endfunction

  function automatic table_req_t random_request();
    table_req_t r;
    int sel;
    r.entry_key   = {$urandom, $urandom};
    r.toxic_kind  = 4'($urandom);
    r.entry_dir   = 2'($urandom);
    r.value_a     = $urandom;
    r.value_b     = $urandom;
    r.query_down  = 1'($urandom);
    r.lever_index = 4'($urandom);
    r.base_value  = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 42)      r.req_type = REQ_ADD;
    else if (sel < 64) r.req_type = REQ_REMOVE;
    else if (sel < 67) r.req_type = REQ_CLEAR;
    else               r.req_type = REQ_COMPOSE;
    // mostly reuse keys so that duplicates and successful removes happen
    if ($urandom_range(0, 99) < 88) r.entry_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    if ($urandom_range(0, 99) < 90) r.toxic_kind = 4'($urandom_range(0, 10));
    if ($urandom_range(0, 99) < 92) r.entry_dir = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 99) < 92) r.lever_index = 4'($urandom_range(0, 12));
    r.value_a = pick_value();
    r.value_b = pick_value();
    if ($urandom_range(0, 99) < 60) r.base_value = pick_value();
    return r;
  endfunction

  function automatic table_req_t make_request(logic [1:0] t, logic [63:0] key, logic [3:0] kind,
                                              logic [1:0] dir, logic [31:0] va, logic [31:0] vb,
                                              logic down, logic [3:0] lever, logic [31:0] base);
    table_req_t r;
    r = '{req_type: t, entry_key: key, toxic_kind: kind, entry_dir: dir, value_a: va,
          value_b: vb, query_down: down, lever_index: lever, base_value: base};
    return r;
  endfunction

  function automatic int pick_gap(int phase_cnt);
    int sel;
    if (phase_cnt % 400 < 80) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Request driver
  table_req_t next_req;
  int send_gap;

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_request(next_req);
        accepted_cnt++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          next_req = queued_requests.pop_front();
          req_if.req_type    <= next_req.req_type;
          req_if.entry_key   <= next_req.entry_key;
          req_if.toxic_kind  <= next_req.toxic_kind;
          req_if.entry_dir   <= next_req.entry_dir;
          req_if.value_a     <= next_req.value_a;
          req_if.value_b     <= next_req.value_b;
          req_if.query_down  <= next_req.query_down;
          req_if.lever_index <= next_req.lever_index;
          req_if.base_value  <= next_req.base_value;
          req_if.valid       <= 1'b1;
          send_gap = pick_gap(accepted_cnt);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  int  stall_left;
  int  hold_left;
  bit  pressure_done;
  table_rsp_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      pressure_done = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        returned_cnt++;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d lever_value %0h",
                 rsp_if.status, rsp_if.lever_value);
          error_cnt++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status mismatch: expected %0d actual %0d", want.status, rsp_if.status);
            error_cnt++;
          end
          if (rsp_if.lever_value !== want.lever_value) begin
            $error("lever_value mismatch: expected %0h actual %0h",
                   want.lever_value, rsp_if.lever_value);
            error_cnt++;
          end
        end
      end
      // hold off for a long stretch once, so the block backs up into the sender
      if (!pressure_done && accepted_cnt >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(returned_cnt + 200);
        rsp_if.ready <= (stall_left == 0);
      end
    end
  end

  // Watchdog on cycles without any handshake
  int idle_cycles;

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_CLEAR;
    req_if.entry_key   = '0;
    req_if.toxic_kind  = '0;
    req_if.entry_dir   = '0;
    req_if.value_a     = '0;
    req_if.value_b     = '0;
    req_if.query_down  = 1'b0;
    req_if.lever_index = '0;
    req_if.base_value  = '0;
    rsp_if.ready       = 1'b0;
    rst = 1'b1;
    shadow_count = 0;
    accepted_cnt = 0;
    returned_cnt = 0;
    error_cnt = 0;
    idle_cycles = 0;
    for (int i = 0; i < 4; i++) begin
      req_seen[i] = 0;
      status_seen[i] = 0;
    end

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

    // Directed: empty compose, fill with every kind and direction, then the corner cases
    queued_requests.push_back(make_request(REQ_COMPOSE, '0, '0, '0, '0, '0, 1'b1,
                                           LEV_LATENCY, 32'hFFFF_FFFF));
    for (int i = 0; i < TABLE_DEPTH; i++)
      queued_requests.push_back(make_request(REQ_ADD, key_pool[i], 4'(i), 2'(i % 4),
                                             (i % 3 == 0) ? 32'hFFFF_FFFF : 32'(i * 1000),
                                             (i % 2 == 1) ? 32'd0 : 32'hFFFF_FFF0,
                                             1'b0, '0, '0));
    queued_requests.push_back(make_request(REQ_ADD, key_pool[16], KIND_LATENCY, DIR_BOTH,
                                           32'd1, 32'd1, 1'b0, '0, '0));
    // duplicate key wins over the full check
    queued_requests.push_back(make_request(REQ_ADD, key_pool[1], KIND_JITTER, DIR_UP,
                                           32'd1, 32'd1, 1'b0, '0, '0));
    queued_requests.push_back(make_request(REQ_COMPOSE, '0, '0, '0, '0, '0, 1'b0,
                                           LEV_LATENCY, 32'd5));
    queued_requests.push_back(make_request(REQ_COMPOSE, '0, '0, '0, '0, '0, 1'b1,
                                           LEV_LOSSY, 32'd10));
    queued_requests.push_back(make_request(REQ_COMPOSE, '0, '0, '0, '0, '0, 1'b0,
                                           4'd15, 32'd123));
    queued_requests.push_back(make_request(REQ_REMOVE, 64'h5A5A_0000_0000_0001, '0, '0,
                                           '0, '0, 1'b0, '0, '0));
    queued_requests.push_back(make_request(REQ_REMOVE, key_pool[0], '0, '0, '0, '0, 1'b0,
                                           '0, '0));
    queued_requests.push_back(make_request(REQ_REMOVE, key_pool[TABLE_DEPTH - 1], '0, '0,
                                           '0, '0, 1'b0, '0, '0));
    queued_requests.push_back(make_request(REQ_COMPOSE, '0, '0, '0, '0, '0, 1'b1,
                                           LEV_CORRUPT, 32'hFFFF_FFFF));
    queued_requests.push_back(make_request(REQ_CLEAR, '1, '1, '1, '1, '1, 1'b1, '1, '1));
    queued_requests.push_back(make_request(REQ_COMPOSE, '0, '0, '0, '0, '0, 1'b0,
                                           LEV_CHUNK, 32'd0));

    for (int i = 0; i < RANDOM_REQS; i++) queued_requests.push_back(random_request());
    total_reqs = queued_requests.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt < total_reqs) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d requests: %0d add, %0d remove, %0d clear, %0d compose.",
             accepted_cnt, req_seen[REQ_ADD], req_seen[REQ_REMOVE], req_seen[REQ_CLEAR],
             req_seen[REQ_COMPOSE]);
    $display("Status mix: %0d ok, %0d key exists, %0d table full, %0d key not found.",
             status_seen[ST_OK], status_seen[ST_EXISTS], status_seen[ST_FULL],
             status_seen[ST_NOT_FOUND]);
    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
